FILE: src/lhcr_pkg.sv
// Package for the level history color ramp block.
// Holds field widths, register reset values and register index codes.
// No dependencies.
package lhcr_pkg;

  localparam int LEVEL_W = 16;
  localparam int COLOR_W = 8;
  localparam int IDX_W   = 3;
  localparam int OUT_W   = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // numerator 510*x for a 16-bit x, and the quotient bit count
  localparam int NUM_W   = LEVEL_W + 9;
  localparam int QBITS   = 8;

  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 16'd1280;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 16'd6400;
  localparam logic [IDX_W-1:0]   LED_COUNT_RST = 3'd7;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [IDX_W-1:0]   led_idx_t;
  typedef logic [OUT_W-1:0]   out_data_t;
  typedef logic [ADDR_W-1:0]  cfg_addr_t;
  typedef logic [DATA_W-1:0]  cfg_data_t;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_MIN_LEVEL = 2'd0,
    REG_MAX_LEVEL = 2'd1,
    REG_LED_COUNT = 2'd2
  } reg_idx_t;

endpackage

FILE: src/level_history_color_ramp.sv
// Level history color ramp: top level with history memory, sequencer and divider.
// Depends on lhcr_pkg.
//
// Usage:
//   Input stream (in_*): one level per item, unsigned Q10.6 in in_tdata.
//   The level goes into a ring history, then the block emits one color per LED
//   on the output stream (out_*): LED 0 from the new level, LED k+1 from
//   history slot k, up to min(led_count, 1+HISTORY_DEPTH) items; tlast marks
//   the final color of an input item. led_count of zero gives no output.
//   APB port sets min_level (0x0), max_level (0x4) and led_count (0x8).
// Sequence:
//   Each color passes through a registered memory read (LEDs past 0), a setup
//   state and the quotient loop, which yields one quotient bit per cycle, and
//   then goes into the output register. One item is processed at a time;
//   in_tready returns as soon as the last color is in the output register,
//   even if that color is still waiting.
// Reset: history reads as zero, write slot zero, registers at their defaults.
// Stall: a held output register stops the sequencer in ST_PUT, with its next result computed.
module level_history_color_ramp #(
  parameter int HISTORY_DEPTH = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  lhcr_pkg::level_t      in_tdata,    // [15:0] level_value
  // output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output lhcr_pkg::out_data_t   out_tdata,   // [2:0] led_index, [10:3] red,
                                             // [18:11] green, [26:19] blue, rest 0
  output logic                  out_tlast,   // last_led
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  lhcr_pkg::cfg_addr_t   paddr,
  input  lhcr_pkg::cfg_data_t   pwdata,
  output lhcr_pkg::cfg_data_t   prdata,
  output logic                  pready
);
  import lhcr_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_PREP,
    ST_DIV,
    ST_PUT
  } state_t;

  // configuration registers
  level_t   min_level_r;
  level_t   max_level_r;
  led_idx_t led_count_r;

  // sequencer
  state_t   state_r;
  led_idx_t k_r;
  led_idx_t total_r;
  level_t   cur_level_r;
  logic [AW-1:0] wr_slot_r;
  logic     valid_r [HISTORY_DEPTH];
  logic     rd_valid_r;
  level_t   rd_data_r;

  // divider
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] den_r;
  color_t   q_r;
  logic [2:0] step_r;
  logic     green_side_r;

  // output register
  logic     out_valid_r;
  led_idx_t out_idx_r;
  color_t   out_red_r;
  color_t   out_green_r;
  logic     out_last_r;

  // history memory
  level_t   hist_mem [HISTORY_DEPTH];

  logic     in_acc;
  logic     cfg_wr;
  logic [AW-1:0] rd_addr;
  led_idx_t total_nxt;

  // no item is taken while reset is held
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign rd_addr   = AW'(k_r - 3'd1);

  // color count, limited by the number of history slots
  always_comb begin
    if (int'(led_count_r) > HISTORY_DEPTH + 1) begin
      total_nxt = IDX_W'(HISTORY_DEPTH + 1);
    end else begin
      total_nxt = led_count_r;
    end
  end

  // setup: clamp, span, and the numerator 510*x = 512x - 2x
  level_t lvl, clamped, span, n_val, diff;
  logic   span_ok, red_half;
  logic [NUM_W-1:0] num_init, den_init;

  always_comb begin
    lvl      = (k_r == '0) ? cur_level_r : (rd_valid_r ? rd_data_r : '0);
    span_ok  = max_level_r > min_level_r;
    if (lvl < min_level_r) begin
      clamped = min_level_r;
    end else if (lvl > max_level_r) begin
      clamped = max_level_r;
    end else begin
      clamped = lvl;
    end
    span     = max_level_r - min_level_r;
    n_val    = clamped - min_level_r;
    red_half = {n_val, 1'b0} < {1'b0, span};
    diff     = red_half ? n_val : (span - n_val);
    num_init = {diff, 9'b0} - {8'b0, diff, 1'b0};
    den_init = {2'b0, span, 7'b0};
    // empty or inverted span: quotient zero on the red side
    if (!span_ok) begin
      num_init = '0;
      den_init = {2'b0, 16'd1, 7'b0};
    end
  end

  // one restoring quotient bit per cycle
  logic             q_bit;
  logic [NUM_W-1:0] rem_nxt;
  assign q_bit   = rem_r >= den_r;
  assign rem_nxt = q_bit ? (rem_r - den_r) : rem_r;

  logic load_out;
  assign load_out = (state_r == ST_PUT) && (!out_valid_r || out_tready);

  // history memory: write on accept, registered read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hist_mem[wr_slot_r] <= in_tdata;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  // sequencer, divider and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      total_r     <= '0;
      wr_slot_r   <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      if (out_valid_r && out_tready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cur_level_r        <= in_tdata;
            valid_r[wr_slot_r] <= 1'b1;
            wr_slot_r <= (wr_slot_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_slot_r + 1'b1;
            k_r       <= '0;
            total_r   <= total_nxt;
            state_r   <= (total_nxt == '0) ? ST_IDLE : ST_PREP;
          end
        end
        ST_RD: begin
          rd_valid_r <= valid_r[rd_addr];
          state_r    <= ST_PREP;
        end
        ST_PREP: begin
          rem_r        <= num_init;
          den_r        <= den_init;
          green_side_r <= span_ok && !red_half;
          step_r       <= '0;
          state_r      <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          den_r  <= den_r >> 1;
          q_r    <= {q_r[QBITS-2:0], q_bit};
          step_r <= step_r + 3'd1;
          if (step_r == 3'(QBITS - 1)) begin
            state_r <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= k_r;
            out_red_r   <= green_side_r ? q_r : COLOR_FULL;
            out_green_r <= green_side_r ? COLOR_FULL : q_r;
            out_last_r  <= (3'(k_r + 3'd1) == total_r);
            if (3'(k_r + 3'd1) == total_r) begin
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + 3'd1;
              state_r <= ST_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r <= MIN_LEVEL_RST;
      max_level_r <= MAX_LEVEL_RST;
      led_count_r <= LED_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_MIN_LEVEL: min_level_r <= pwdata[LEVEL_W-1:0];
        REG_MAX_LEVEL: max_level_r <= pwdata[LEVEL_W-1:0];
        REG_LED_COUNT: led_count_r <= pwdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_MIN_LEVEL: prdata = {{(DATA_W-LEVEL_W){1'b0}}, min_level_r};
      REG_MAX_LEVEL: prdata = {{(DATA_W-LEVEL_W){1'b0}}, max_level_r};
      REG_LED_COUNT: prdata = {{(DATA_W-IDX_W){1'b0}}, led_count_r};
      default:       prdata = '0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_W-IDX_W-3*COLOR_W){1'b0}}, {COLOR_W{1'b0}},
                       out_green_r, out_red_r, out_idx_r};

`ifndef SYNTHESIS
  // LED 0 never goes through a memory read
  a_rd_not_led0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (k_r != '0))
    else $error("memory read issued for LED 0");

  // final remainder stays below the span
  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == 3'(QBITS - 1)) |-> (rem_nxt < den_r))
    else $error("quotient overflow in color divider");

  // every emitted color lies inside the LED count of this item
  a_idx_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (k_r < total_r))
    else $error("LED index at or above color count");

  // an accepted level marks its history slot as written
  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> valid_r[$past(wr_slot_r)])
    else $error("history slot not marked after write");
`endif

endmodule

FILE: tb/level_history_color_ramp_tb.sv
// Self-checking testbench for level_history_color_ramp: drives levels on the
// input stream, programs the APB registers between phases and checks every
// output color against a local ramp model. Depends on lhcr_pkg and the block.
`timescale 1ns / 1ps

module level_history_color_ramp_tb;
  import lhcr_pkg::*;

  localparam int          HIST_DEPTH   = 6;
  localparam int          MAX_LEDS     = 1 + HIST_DEPTH;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          PHASE_ITEMS  = 50;
  localparam int          RAND_PHASES  = 7;
  localparam cfg_addr_t   UNUSED_ADDR  = 4'hC;

  typedef struct packed {
    led_idx_t led;
    color_t   red;
    color_t   green;
    color_t   blue;
    logic     last;
  } led_color_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // block ports; the inputs driven from here are all known from time zero
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  level_t      in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  out_data_t   out_tdata;
  logic        out_tlast;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  cfg_addr_t   paddr      = '0;
  cfg_data_t   pwdata     = '0;
  cfg_data_t   prdata;
  logic        pready;

  // stimulus and expectation stores
  level_t      level_queue[$];
  led_color_t  color_expect_q[$];
  led_color_t  head_color;

  // model state: register copies and ring history
  level_t      cur_min   = MIN_LEVEL_RST;
  level_t      cur_max   = MAX_LEVEL_RST;
  led_idx_t    cur_count = LED_COUNT_RST;
  level_t      level_hist[HIST_DEPTH];
  int unsigned hist_slot = 0;

  // idling control
  logic        in_idle_on  = 1'b1;
  logic        out_idle_on = 1'b1;
  int unsigned in_gap      = 0;
  int unsigned out_gap     = 0;
  int unsigned out_draw;

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  level_history_color_ramp #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [15:0] level_value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [2:0] led_index, [10:3] red, [18:11] green, [26:19] blue
    .out_tlast  (out_tlast),    // last_led
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // red-yellow-green ramp for one level under the current span
  function automatic void ramp_color(input level_t lvl, output color_t r, output color_t g);
    int unsigned v;
    int unsigned span;
    int unsigned off;
    v = lvl;
    if (cur_max <= cur_min) begin
      r = COLOR_FULL;
      g = '0;
    end else begin
      if (v < cur_min) v = cur_min;
      else if (v > cur_max) v = cur_max;
      span = cur_max - cur_min;
      off  = v - cur_min;
      if (2 * off < span) begin
        r = COLOR_FULL;
        g = color_t'((510 * off) / span);
      end else begin
        r = color_t'((510 * (span - off)) / span);
        g = COLOR_FULL;
      end
    end
  endfunction

  // store the level in the ring, then queue the colors it produces
  function automatic void predict_colors(input level_t lvl);
    int unsigned total;
    led_color_t  c;
    level_hist[hist_slot] = lvl;
    hist_slot = (hist_slot + 1) % HIST_DEPTH;
    total = (cur_count > MAX_LEDS) ? MAX_LEDS : cur_count;
    for (int unsigned k = 0; k < total; k++) begin
      c.led  = led_idx_t'(k);
      ramp_color((k == 0) ? lvl : level_hist[k-1], c.red, c.green);
      c.blue = '0;
      c.last = (k + 1 == total);
      color_expect_q.push_back(c);
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // input driver: one item per handshake, random gap drawn per item while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the item until taken
    end else if (in_gap != 0) begin
      in_tvalid <= 1'b0;
      in_gap    <= in_gap - 1;
    end else if (level_queue.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= level_queue.pop_front();
      in_gap    <= in_idle_on ? $urandom_range(0, 7) : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // output ready: random stall after each accepted color while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (out_tvalid && out_tready) begin
      out_draw    = out_idle_on ? $urandom_range(0, 7) : 0;
      out_gap    <= out_draw;
      out_tready <= (out_draw == 0);
    end else if (out_gap != 0) begin
      out_gap    <= out_gap - 1;
      out_tready <= (out_gap == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: compare colors, then predict for a newly accepted level
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (color_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected color, expected none actual %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          head_color = color_expect_q.pop_front();
          check_field("led_index", head_color.led,   out_tdata[2:0]);
          check_field("red",       head_color.red,   out_tdata[10:3]);
          check_field("green",     head_color.green, out_tdata[18:11]);
          check_field("blue",      head_color.blue,  out_tdata[26:19]);
          check_field("pad",       0,                out_tdata[31:27]);
          check_field("last_led",  head_color.last,  out_tlast);
        end
      end
      if (in_tvalid && in_tready) predict_colors(in_tdata);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[level_history_color_ramp] ERROR");
      $finish;
    end
  end

  // one APB transfer: setup, access, complete on pready
  task automatic apb_xfer(input logic wr, input cfg_addr_t addr, input cfg_data_t wdata,
                          output cfg_data_t rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // register write with junk in the unused upper bits
  task automatic reg_write(input cfg_addr_t addr, input int unsigned value);
    cfg_data_t junk;
    apb_xfer(1'b1, addr, ($urandom() & 32'hFFFF_0000) | value, junk);
    case (addr[3:2])
      REG_MIN_LEVEL: cur_min   = level_t'(value);
      REG_MAX_LEVEL: cur_max   = level_t'(value);
      REG_LED_COUNT: cur_count = led_idx_t'(value);
      default: ;
    endcase
  endtask

  task automatic reg_readback();
    cfg_data_t got;
    apb_xfer(1'b0, cfg_addr_t'({REG_MIN_LEVEL, 2'b00}), '0, got);
    check_field("min_level readback", cur_min, got[15:0]);
    apb_xfer(1'b0, cfg_addr_t'({REG_MAX_LEVEL, 2'b00}), '0, got);
    check_field("max_level readback", cur_max, got[15:0]);
    apb_xfer(1'b0, cfg_addr_t'({REG_LED_COUNT, 2'b00}), '0, got);
    check_field("led_count readback", cur_count, got[2:0]);
  endtask

  task automatic set_ramp(input int unsigned lo, input int unsigned hi, input int unsigned cnt);
    reg_write(cfg_addr_t'({REG_MIN_LEVEL, 2'b00}), lo & 16'hFFFF);
    reg_write(cfg_addr_t'({REG_MAX_LEVEL, 2'b00}), hi & 16'hFFFF);
    reg_write(cfg_addr_t'({REG_LED_COUNT, 2'b00}), cnt & 3'h7);
    reg_readback();
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (level_queue.size() != 0 || in_tvalid || color_expect_q.size() != 0);
  endtask

  // drained, then room for a color still being computed with no result due
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // random level: near the span, at its boundaries or midpoint, or over the full range
  function automatic level_t rand_level();
    int unsigned sel;
    int unsigned lo;
    int unsigned hi;
    sel = $urandom_range(0, 5);
    if (sel == 0 || cur_max <= cur_min) return level_t'($urandom());
    if (sel == 1) return cur_min;
    if (sel == 2) return cur_max;
    if (sel == 3) return level_t'((cur_min + cur_max + $urandom_range(0, 1)) / 2);
    lo = (cur_min > 64) ? cur_min - 64 : 0;
    hi = (cur_max + 64 > 65535) ? 65535 : cur_max + 64;
    return level_t'($urandom_range(hi, lo));
  endfunction

  task automatic rand_ramp(input int unsigned phase);
    int unsigned mode;
    int unsigned lo;
    int unsigned hi;
    int unsigned cnt;
    mode = $urandom_range(0, 5);
    case (mode)
      0: begin lo = $urandom_range(0, 65535); hi = $urandom_range(0, 65535); end
      1: begin lo = 0; hi = 65535; end
      2: begin lo = $urandom_range(0, 65532); hi = lo + $urandom_range(1, 3); end
      3: begin lo = $urandom_range(0, 65535); hi = lo; end
      4: begin hi = $urandom_range(0, 30000); lo = hi + $urandom_range(1, 30000); end
      default: begin lo = $urandom_range(0, 8000); hi = lo + $urandom_range(1, 20000); end
    endcase
    if (phase == 0) cnt = MAX_LEDS;
    else if (phase == 1) cnt = 1;
    else cnt = $urandom_range(0, 7);
    set_ramp(lo, hi, cnt);
  endtask

  initial begin : stimulus
    cfg_data_t junk;
    for (int i = 0; i < HIST_DEPTH; i++) level_hist[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults after reset, then levels around the default span edges
    reg_readback();
    level_queue = '{16'd0, 16'd1279, 16'd1280, 16'd1281, 16'd3839, 16'd3840,
                    16'd6399, 16'd6400, 16'd6401, 16'hFFFF, 16'h5555, 16'hAAAA};
    settle();

    // full range span
    set_ramp(0, 65535, 7);
    level_queue = '{16'd0, 16'hFFFF, 16'd32767, 16'd32768};
    settle();

    // empty span, three LEDs
    set_ramp(1000, 1000, 3);
    level_queue = '{16'd500, 16'd1000, 16'd2000};
    settle();

    // inverted span, single LED
    set_ramp(60000, 100, 1);
    level_queue = '{16'd0, 16'd30000, 16'hFFFF};
    settle();

    // no LEDs: history still advances, nothing comes out
    set_ramp(1280, 6400, 0);
    level_queue = '{16'd4000, 16'd9000};
    settle();

    // write to the unused register slot must change nothing
    apb_xfer(1'b1, UNUSED_ADDR, $urandom(), junk);
    reg_readback();

    // random phases with fresh settings each time
    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      rand_ramp(phase);
      in_idle_on  = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      out_idle_on = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        level_queue.push_back(rand_level());
        // mid-phase hold-off until every color is out
        if (phase == 3 && n == PHASE_ITEMS / 2) wait_drained();
      end
      settle();
    end

    if (color_expect_q.size() != 0) begin
      fail_count++;
      $display("%0t: colors left over, expected %0d actual 0", $time, color_expect_q.size());
    end
    if (fail_count == 0) begin
      $display("[level_history_color_ramp] OK");
    end else begin
      $display("[level_history_color_ramp] ERROR");
    end
    $finish;
  end

endmodule
